@@ rtl/ptd_pkg.sv @@
// Package for the periodic task dispatcher: operation codes and the per-cell
// control struct. No dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_POLL = 2'd1,
    OP_ADD  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Control handed to each slot cell for one accepted beat.
  typedef struct packed {
    logic tick;    // decrement enabled countdown
    logic poll;    // clear ready flag if this cell wins
    logic load;    // add addressed to this cell
    logic enable;  // slot_enable of the add beat
  } cell_ctl_t;

endpackage

@@ rtl/ptd_in_if.sv @@
// Input channel of the periodic task dispatcher: valid/ready plus one item.
// Depends on nothing.
`timescale 1ns / 1ps

interface ptd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  slot_index;
  logic [15:0] period_ticks;
  logic        slot_enable;

  modport source (output valid, output operation, output slot_index,
                  output period_ticks, output slot_enable, input ready);
  modport sink   (input valid, input operation, input slot_index,
                  input period_ticks, input slot_enable, output ready);
endinterface

@@ rtl/ptd_out_if.sv @@
// Result channel of the periodic task dispatcher: valid/ready plus one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface ptd_out_if;
  logic       valid;
  logic       ready;
  logic       run_valid;
  logic [2:0] run_slot;
  logic [7:0] ready_mask;

  modport source (output valid, output run_valid, output run_slot,
                  output ready_mask, input ready);
  modport sink   (input valid, input run_valid, input run_slot,
                  input ready_mask, output ready);
endinterface

@@ rtl/ptd_cell.sv @@
// One task slot: countdown, period, enable and ready flag.
// Depends on ptd_pkg. Chained through taken_i/taken_o for poll priority.
`timescale 1ns / 1ps

module ptd_cell import ptd_pkg::*; #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic [PERIOD_BITS-1:0] period_i,
  input  logic                   taken_i,
  output logic                   taken_o,
  output logic                   grant_o,
  output logic                   ready_d_o
);

  logic [PERIOD_BITS-1:0] cnt_q, cnt_d, per_q, per_d, cnt_dec;
  logic                   en_q, en_d, rdy_q, rdy_d;

  // a higher-priority cell already holds a ready flag
  assign grant_o   = rdy_q & ~taken_i;
  assign taken_o   = taken_i | rdy_q;
  assign ready_d_o = rdy_d;
  assign cnt_dec   = cnt_q - PERIOD_BITS'(1);

  always_comb begin
    cnt_d = cnt_q;
    per_d = per_q;
    en_d  = en_q;
    rdy_d = rdy_q;
    if (ctl_i.load) begin
      per_d = period_i;
      cnt_d = period_i;
      rdy_d = 1'b0;
      en_d  = ctl_i.enable & (|period_i);
    end else if (ctl_i.tick && en_q) begin
      if (cnt_dec == '0) begin
        rdy_d = 1'b1;
        cnt_d = per_q;
      end else begin
        cnt_d = cnt_dec;
      end
    end else if (ctl_i.poll && grant_o) begin
      rdy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      per_q <= '0;
      en_q  <= 1'b0;
      rdy_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      per_q <= per_d;
      en_q  <= en_d;
      rdy_q <= rdy_d;
    end
  end

endmodule

@@ rtl/periodic_task_dispatcher_top.sv @@
// Periodic task dispatcher: row of slot cells, poll priority ripples 0 -> N-1.
// The result beat is registered and follows in the cycle after the item beat. One item
// per cycle while out_o.ready is not held low; all cells update in parallel on accept.
// The result register frees in the cycle its beat is taken.
// Reset (rst_ni low, async) clears every slot: no task enabled, none ready.
// Depends on ptd_pkg, ptd_in_if, ptd_out_if, ptd_cell.
`timescale 1ns / 1ps

module periodic_task_dispatcher_top import ptd_pkg::*; #(
  parameter int NUM_SLOTS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptd_in_if.sink    in_i,
  ptd_out_if.source out_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                   accept;
  op_e                    op;
  logic [PERIOD_BITS+15:0] per_ext;
  logic [PERIOD_BITS-1:0] period;
  logic [NUM_SLOTS:0]     taken;
  logic [NUM_SLOTS-1:0]   grant, ready_d;
  logic [NUM_SLOTS+7:0]   ready_pad;
  logic [IdxW-1:0]        idx;
  logic [31:0]            idx_ext;
  logic                   is_poll;

  logic       out_valid_q, run_valid_q;
  logic [2:0] run_slot_q;
  logic [7:0] ready_mask_q;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign op         = op_e'(in_i.operation);
  assign per_ext    = {{PERIOD_BITS{1'b0}}, in_i.period_ticks};
  assign period     = per_ext[PERIOD_BITS-1:0];
  assign is_poll    = (op == OP_POLL);
  assign taken[0]   = 1'b0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.tick   = accept & (op == OP_TICK);
    assign ctl.poll   = accept & is_poll;
    assign ctl.load   = accept & (op == OP_ADD) & (32'(in_i.slot_index) == i);
    assign ctl.enable = in_i.slot_enable;

    ptd_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .period_i  (period),
      .taken_i   (taken[i]),
      .taken_o   (taken[i+1]),
      .grant_o   (grant[i]),
      .ready_d_o (ready_d[i])
    );
  end

  // grant is one-hot or zero, so OR of the indexes encodes it
  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (grant[i]) idx = idx | IdxW'(i);
    end
  end

  assign idx_ext   = 32'(idx);
  assign ready_pad = {8'h00, ready_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_valid_q  <= is_poll & (|grant);
      run_slot_q   <= (is_poll & (|grant)) ? idx_ext[2:0] : 3'd0;
      ready_mask_q <= ready_pad[7:0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.run_valid  = run_valid_q;
  assign out_o.run_slot   = run_slot_q;
  assign out_o.ready_mask = ready_mask_q;

endmodule
